// ===== src/sma_pkg.sv =====
// Shared types, constants and helpers for the sorted MAC address table.
package sma_pkg;

    // Table geometry
    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int KIND_W = 3;
    localparam int MAC_W  = 64;
    localparam int SA_W   = 16;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int CNTO_W = 6;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input item
        logic cmp;    // compare the key against every cell
        logic apply;  // update the cells and load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid;  // result register holds an item
    } stat_t;

    // Clamp a position to the result field
    function automatic logic [POS_W-1:0] sat_pos(input int v);
        logic [POS_W-1:0] r;
        r = (v > 31) ? POS_W'(31) : POS_W'(v);
        return r;
    endfunction

    // Clamp a count to the result field
    function automatic logic [CNTO_W-1:0] sat_cnt(input int v);
        logic [CNTO_W-1:0] r;
        r = (v > 63) ? CNTO_W'(63) : CNTO_W'(v);
        return r;
    endfunction

endpackage

// ===== src/sma_ctrl.sv =====
// Controller state machine that sequences capture, compare and update.
module sma_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_ready,
    input  sma_pkg::stat_t stat,
    output sma_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    // Result register can take a new item this cycle
    assign out_free = !stat.out_valid || out_ready;

    // Accept while idle, or while finishing the current item
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_APPLY) && out_free);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.cmp   = (state_reg == S_CMP);
    assign cmd.apply = (state_reg == S_APPLY) && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = cmd.load ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A compare is always followed by the update stage
    a_cmp_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_APPLY))
        else $error("compare not followed by update");

    // No item is taken while a compare is in flight
    a_no_load_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !cmd.load)
        else $error("item accepted during compare");

    // Update happens only when the result register is free
    a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!stat.out_valid || out_ready))
        else $error("update while result register is blocked");

endmodule

// ===== src/sma_dp.sv =====
// Datapath: sorted cell row, parallel key compare, shift update and result register.
module sma_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sma_pkg::cmd_t                 cmd,
    output sma_pkg::stat_t                stat,
    input  logic [sma_pkg::KIND_W-1:0]    in_kind,
    input  logic [sma_pkg::MAC_W-1:0]     in_mac,
    input  logic [sma_pkg::SA_W-1:0]      in_sa,
    input  logic [sma_pkg::POS_W-1:0]     in_pos,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [sma_pkg::STAT_W-1:0]    out_status,
    output logic [sma_pkg::SA_W-1:0]      out_addr,
    output logic [sma_pkg::POS_W-1:0]     out_pos,
    output logic [sma_pkg::CNTO_W-1:0]    out_count
);

    localparam int DEPTH = sma_pkg::DEPTH;
    localparam int CNT_W = sma_pkg::CNT_W;

    // Captured item
    logic [sma_pkg::KIND_W-1:0] kind_reg;
    logic [sma_pkg::MAC_W-1:0]  mac_reg;
    logic [sma_pkg::SA_W-1:0]   sa_reg;
    logic [sma_pkg::POS_W-1:0]  pos_reg;

    // Cell row
    logic [sma_pkg::MAC_W-1:0] key_reg  [DEPTH];
    logic [sma_pkg::MAC_W-1:0] key_next [DEPTH];
    logic [sma_pkg::SA_W-1:0]  addr_reg [DEPTH];
    logic [sma_pkg::SA_W-1:0]  addr_next[DEPTH];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // Compare results
    logic [DEPTH-1:0] lt_reg;
    logic [DEPTH-1:0] lt_next;
    logic [DEPTH-1:0] sel_reg;
    logic [DEPTH-1:0] sel_next;

    // Result register
    logic                       out_valid_reg;
    logic [sma_pkg::STAT_W-1:0] status_reg, status_next;
    logic [sma_pkg::SA_W-1:0]   faddr_reg, faddr_next;
    logic [sma_pkg::POS_W-1:0]  fpos_reg, fpos_next;
    logic [sma_pkg::CNTO_W-1:0] fcnt_reg, fcnt_next;

    // Update stage helpers
    logic [CNT_W-1:0]         ins_pt;
    logic                     hit;
    logic [sma_pkg::SA_W-1:0] sel_addr;
    logic                     full;

    // Compare every valid cell against the key, pick the cell to report
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            logic vld;
            vld         = CNT_W'(i) < count_reg;
            lt_next[i]  = vld && (key_reg[i] < mac_reg);
            if (kind_reg == sma_pkg::KIND_READ)
            begin
                sel_next[i] = vld && (i == int'(pos_reg));
            end
            else
            begin
                sel_next[i] = vld && (key_reg[i] == mac_reg);
            end
        end
    end

    // Insertion point is the first cell not below the key
    always_comb
    begin
        ins_pt = CNT_W'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!lt_reg[i])
            begin
                ins_pt = CNT_W'(i);
            end
        end
    end

    // Gather the address of the selected cell
    always_comb
    begin
        sel_addr = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_addr = sel_addr | (sel_reg[i] ? addr_reg[i] : '0);
        end
    end

    assign hit  = |sel_reg;
    assign full = (count_reg == CNT_W'(DEPTH));

    // Build the update and the result
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_next[i]  = key_reg[i];
            addr_next[i] = addr_reg[i];
        end
        count_next  = count_reg;
        status_next = sma_pkg::ST_OK;
        faddr_next  = '0;
        fpos_next   = '0;
        case (kind_reg)
            sma_pkg::KIND_LOOKUP:
            begin
                fpos_next = sma_pkg::sat_pos(int'(ins_pt));
                if (hit)
                begin
                    faddr_next = sel_addr;
                end
                else
                begin
                    status_next = sma_pkg::ST_NOT_FOUND;
                end
            end
            sma_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = sma_pkg::ST_FULL;
                end
                else if (hit)
                begin
                    status_next = sma_pkg::ST_DUPLICATE;
                    faddr_next  = sel_addr;
                    fpos_next   = sma_pkg::sat_pos(int'(ins_pt));
                end
                else
                begin
                    faddr_next = sa_reg;
                    fpos_next  = sma_pkg::sat_pos(int'(ins_pt));
                    count_next = count_reg + CNT_W'(1);
                    // open a gap at the insertion point
                    if (ins_pt == '0)
                    begin
                        key_next[0]  = mac_reg;
                        addr_next[0] = sa_reg;
                    end
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (CNT_W'(i) > ins_pt)
                        begin
                            key_next[i]  = key_reg[i-1];
                            addr_next[i] = addr_reg[i-1];
                        end
                        else if (CNT_W'(i) == ins_pt)
                        begin
                            key_next[i]  = mac_reg;
                            addr_next[i] = sa_reg;
                        end
                    end
                end
            end
            sma_pkg::KIND_DELETE:
            begin
                fpos_next = sma_pkg::sat_pos(int'(ins_pt));
                if (hit)
                begin
                    faddr_next = sel_addr;
                    count_next = count_reg - CNT_W'(1);
                    // close the gap
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if (CNT_W'(i) >= ins_pt)
                        begin
                            key_next[i]  = key_reg[i+1];
                            addr_next[i] = addr_reg[i+1];
                        end
                    end
                end
                else
                begin
                    status_next = sma_pkg::ST_NOT_FOUND;
                end
            end
            sma_pkg::KIND_CLEAR:
            begin
                count_next = '0;
            end
            sma_pkg::KIND_READ:
            begin
                fpos_next = pos_reg;
                if (hit)
                begin
                    faddr_next = sel_addr;
                end
                else
                begin
                    status_next = sma_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_next = sma_pkg::ST_OK;
            end
        endcase
        fcnt_next = sma_pkg::sat_cnt(int'(count_next));
    end

    // Capture the item, compare, update the cells, load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            mac_reg  <= in_mac;
            sa_reg   <= in_sa;
            pos_reg  <= in_pos;
        end
        if (cmd.cmp)
        begin
            lt_reg  <= lt_next;
            sel_reg <= sel_next;
        end
        if (cmd.apply)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                key_reg[i]  <= key_next[i];
                addr_reg[i] <= addr_next[i];
            end
            status_reg <= status_next;
            faddr_reg  <= faddr_next;
            fpos_reg   <= fpos_next;
            fcnt_reg   <= fcnt_next;
        end
    end

    // Control state: entry count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_addr       = faddr_reg;
    assign out_pos        = fpos_reg;
    assign out_count      = fcnt_reg;

    // Count never exceeds the table size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table size");

    // An update always leaves a result waiting
    a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> out_valid_reg)
        else $error("update produced no result");

    // The first two stored keys stay in ascending order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (key_reg[0] < key_reg[1]))
        else $error("cells out of order");

endmodule

// ===== src/sorted_mac_address_table.sv =====
// Sorted MAC address table: top level joining the controller and the datapath.
// Usage:
//   Commands enter on the s_ channel: s_tuser carries the kind (lookup, insert,
//   delete, clear, read at position), s_tdata the key, short address and position.
//   Each command gives exactly one result on the m_ channel: m_tuser carries the
//   status, m_tdata the short address, sorted position and entry count.
//   Keys are held in a row of cells kept in ascending order; a command compares
//   its key against every cell in the compare state, then shifts the cells in the update state.
//   Each accepted item is compared, then updated, and the update loads its result onto m_tvalid.
//   The next item is accepted only as the current one finishes, set by the compare/update sequence
//   over the cell row; s_tready rises again in the update cycle once the result register is free.
//   A finished result waits in the output register while the next item is
//   accepted and compared; if m_tready stays low the update of that next item
//   holds until the result register is taken, and s_tready stays low meanwhile.
//   Reset empties the table (entry count zero) and drops any waiting result;
//   cell contents are not cleared and are never read before being written.
module sorted_mac_address_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // mac [63:0], short_addr [79:64], position [84:80], zero
    input  logic [2:0]  s_tuser,   // kind [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // found_addr [15:0], found_pos [20:16], count_now [26:21], zero
    output logic [2:0]  m_tuser    // status [2:0]
);

    sma_pkg::cmd_t  cmd;
    sma_pkg::stat_t stat;

    logic [sma_pkg::SA_W-1:0]   found_addr;
    logic [sma_pkg::POS_W-1:0]  found_pos;
    logic [sma_pkg::CNTO_W-1:0] count_now;

    sma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sma_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_mac     (s_tdata[63:0]),
        .in_sa      (s_tdata[79:64]),
        .in_pos     (s_tdata[84:80]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_addr   (found_addr),
        .out_pos    (found_pos),
        .out_count  (count_now)
    );

    // Pack the result fields
    assign m_tdata = {5'd0, count_now, found_pos, found_addr};

endmodule

// ===== bench/tb.sv =====
// Testbench for the sorted MAC address table: directed rows and random command traffic.
`timescale 1ns / 100ps

module tb;

    // Kinds the block treats as no operation
    localparam logic [sma_pkg::KIND_W-1:0] KIND_SPARE5 = 3'd5;
    localparam logic [sma_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [sma_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

    localparam logic [sma_pkg::MAC_W-1:0] MAC_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [sma_pkg::MAC_W-1:0] MAC_MID = 64'h8000_0000_0000_0000;

    localparam int RAND_ITEMS  = 500;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [sma_pkg::KIND_W-1:0] kind;
        logic [sma_pkg::MAC_W-1:0]  mac;
        logic [sma_pkg::SA_W-1:0]   sa;
        logic [sma_pkg::POS_W-1:0]  posn;
    } tbl_cmd_t;

    typedef struct packed {
        logic [sma_pkg::STAT_W-1:0] status;
        logic [sma_pkg::SA_W-1:0]   addr;
        logic [sma_pkg::POS_W-1:0]  pos;
        logic [sma_pkg::CNTO_W-1:0] cnt;
    } tbl_res_t;

    typedef struct {
        tbl_cmd_t cmd;
        bit       fixed;
        tbl_res_t res;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Shadow copy of the table contents
    logic [sma_pkg::MAC_W-1:0] key_tab  [sma_pkg::DEPTH];
    logic [sma_pkg::SA_W-1:0]  addr_tab [sma_pkg::DEPTH];
    int                        entry_cnt = 0;

    tbl_res_t table_replies[$];
    dir_row_t dir_rows[$];
    int       mismatch_cnt    = 0;
    int       items_sent      = 0;
    int       idle_cycles     = 0;
    int       sender_idle_pct = 0;
    int       stall_pct       = 0;

    sorted_mac_address_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow table and return its reply
    function automatic tbl_res_t apply_table_cmd(input tbl_cmd_t c);
        tbl_res_t                  r;
        int                        p;
        int                        i;
        bit                        hit;
        logic [sma_pkg::POS_W-1:0] p_out;
        r = '0;
        p = 0;
        while (p < entry_cnt && key_tab[p] < c.mac)
            p++;
        hit = (p < entry_cnt) && (key_tab[p] == c.mac);
        p_out = (p > 31) ? 5'd31 : 5'(p);
        case (c.kind)
            sma_pkg::KIND_LOOKUP, sma_pkg::KIND_DELETE:
            begin
                r.pos = p_out;
                if (!hit)
                    r.status = sma_pkg::ST_NOT_FOUND;
                else
                begin
                    r.addr = addr_tab[p];
                    if (c.kind == sma_pkg::KIND_DELETE)
                    begin
                        // close the gap and zero the freed slot
                        for (i = p; i < entry_cnt - 1; i++)
                        begin
                            key_tab[i]  = key_tab[i + 1];
                            addr_tab[i] = addr_tab[i + 1];
                        end
                        entry_cnt--;
                        key_tab[entry_cnt]  = '0;
                        addr_tab[entry_cnt] = '0;
                    end
                end
            end
            sma_pkg::KIND_INSERT:
            begin
                // full table is rejected before the duplicate check
                if (entry_cnt >= sma_pkg::DEPTH)
                    r.status = sma_pkg::ST_FULL;
                else if (hit)
                begin
                    r.status = sma_pkg::ST_DUPLICATE;
                    r.addr   = addr_tab[p];
                    r.pos    = p_out;
                end
                else
                begin
                    for (i = entry_cnt; i > p; i--)
                    begin
                        key_tab[i]  = key_tab[i - 1];
                        addr_tab[i] = addr_tab[i - 1];
                    end
                    key_tab[p]  = c.mac;
                    addr_tab[p] = c.sa;
                    entry_cnt++;
                    r.addr = c.sa;
                    r.pos  = p_out;
                end
            end
            sma_pkg::KIND_CLEAR:
            begin
                for (i = 0; i < sma_pkg::DEPTH; i++)
                begin
                    key_tab[i]  = '0;
                    addr_tab[i] = '0;
                end
                entry_cnt = 0;
            end
            sma_pkg::KIND_READ:
            begin
                r.pos = c.posn;
                if (c.posn >= entry_cnt)
                    r.status = sma_pkg::ST_RANGE;
                else
                    r.addr = addr_tab[c.posn];
            end
            default:
            begin
            end
        endcase
        r.cnt = (entry_cnt > 63) ? 6'd63 : 6'(entry_cnt);
        return r;
    endfunction

    // Random key: wide, clustered near zero, near all-ones, or high bit set
    function automatic logic [sma_pkg::MAC_W-1:0] fresh_mac();
        case ($urandom_range(0, 3))
            0: return {$urandom(), $urandom()};
            1: return 64'($urandom_range(0, 63));
            2: return ~64'($urandom_range(0, 63));
            default: return {1'b1, 31'($urandom()), 32'($urandom_range(0, 255))};
        endcase
    endfunction

    // Key already in the table, or a fresh one when the table is empty
    function automatic logic [sma_pkg::MAC_W-1:0] known_mac();
        if (entry_cnt == 0)
            return fresh_mac();
        return key_tab[$urandom_range(0, entry_cnt - 1)];
    endfunction

    // Read position: mostly at or below the count, sometimes anywhere
    function automatic logic [sma_pkg::POS_W-1:0] pick_posn();
        int top;
        top = (entry_cnt > 31) ? 31 : entry_cnt;
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, top));
    endfunction

    task automatic add_row(input logic [sma_pkg::KIND_W-1:0] kind,
                           input logic [sma_pkg::MAC_W-1:0] mac,
                           input logic [sma_pkg::SA_W-1:0] sa,
                           input logic [sma_pkg::POS_W-1:0] posn,
                           input bit fixed, input logic [sma_pkg::STAT_W-1:0] status,
                           input logic [sma_pkg::SA_W-1:0] addr,
                           input logic [sma_pkg::POS_W-1:0] pos,
                           input logic [sma_pkg::CNTO_W-1:0] cnt);
        dir_row_t row;
        row.cmd.kind   = kind;
        row.cmd.mac    = mac;
        row.cmd.sa     = sa;
        row.cmd.posn   = posn;
        row.fixed      = fixed;
        row.res.status = status;
        row.res.addr   = addr;
        row.res.pos    = pos;
        row.res.cnt    = cnt;
        dir_rows.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then record its reply
    task automatic drive_cmd(input tbl_cmd_t c, input bit fixed, input tbl_res_t fixed_res);
        tbl_res_t r;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.kind;
        s_tdata  <= {3'b000, c.posn, c.sa, c.mac};
        do
            @(posedge clk);
        while (!s_tready);
        r = apply_table_cmd(c);
        table_replies.push_back(fixed ? fixed_res : r);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [sma_pkg::KIND_W-1:0] kind,
                            input logic [sma_pkg::MAC_W-1:0] mac,
                            input logic [sma_pkg::POS_W-1:0] posn);
        tbl_cmd_t c;
        c.kind = kind;
        c.mac  = mac;
        c.sa   = 16'($urandom());
        c.posn = posn;
        drive_cmd(c, 1'b0, '0);
    endtask

    task automatic log_mismatch(input string what, input tbl_res_t want, input tbl_res_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t %s: status %0d/%0d addr %h/%h pos %0d/%0d count %0d/%0d (exp/got)",
                     $realtime, what, want.status, got.status, want.addr, got.addr,
                     want.pos, got.pos, want.cnt, got.cnt);
    endtask

    // Check each reply against the oldest outstanding one, then roll backpressure
    always @(posedge clk)
    begin : reply_check
        tbl_res_t got;
        tbl_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[15:0], m_tdata[20:16], m_tdata[26:21]};
            if (table_replies.size() == 0)
                log_mismatch("reply with nothing outstanding", '0, got);
            else
            begin
                want = table_replies.pop_front();
                if (got.status !== want.status || got.addr !== want.addr
                    || got.pos !== want.pos || got.cnt !== want.cnt)
                    log_mismatch("reply mismatch", want, got);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort when no item moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int                         ep;
        int                         roll;
        logic [sma_pkg::KIND_W-1:0] k;

        // Directed rows: fixed replies where obvious, predictor elsewhere
        //   kind, mac, sa, posn
        //   fix, status, addr, pos, cnt
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd0,
                1, sma_pkg::ST_RANGE, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_LOOKUP, 64'h0, 16'h0, 5'd0,
                1, sma_pkg::ST_NOT_FOUND, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_DELETE, MAC_MAX, 16'h0, 5'd0,
                1, sma_pkg::ST_NOT_FOUND, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_INSERT, 64'h0, 16'hFFFF, 5'd0,
                1, sma_pkg::ST_OK, 16'hFFFF, 5'd0, 6'd1);
        add_row(sma_pkg::KIND_INSERT, MAC_MAX, 16'h0, 5'd0,
                1, sma_pkg::ST_OK, 16'h0, 5'd1, 6'd2);
        add_row(sma_pkg::KIND_INSERT, MAC_MID, 16'h1234, 5'd0,
                1, sma_pkg::ST_OK, 16'h1234, 5'd1, 6'd3);
        add_row(sma_pkg::KIND_INSERT, 64'h0, 16'h5555, 5'd0,
                1, sma_pkg::ST_DUPLICATE, 16'hFFFF, 5'd0, 6'd3);
        add_row(sma_pkg::KIND_LOOKUP, MAC_MAX, 16'h0, 5'd0,
                1, sma_pkg::ST_OK, 16'h0, 5'd2, 6'd3);
        add_row(sma_pkg::KIND_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0, 5'd0,
                1, sma_pkg::ST_NOT_FOUND, 16'h0, 5'd1, 6'd3);
        add_row(sma_pkg::KIND_DELETE, 64'h42, 16'h0, 5'd0,
                1, sma_pkg::ST_NOT_FOUND, 16'h0, 5'd1, 6'd3);
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd31,
                1, sma_pkg::ST_RANGE, 16'h0, 5'd31, 6'd3);
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd3,
                1, sma_pkg::ST_RANGE, 16'h0, 5'd3, 6'd3);
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd2,
                1, sma_pkg::ST_OK, 16'h0, 5'd2, 6'd3);
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd1,
                1, sma_pkg::ST_OK, 16'h1234, 5'd1, 6'd3);
        add_row(sma_pkg::KIND_DELETE, MAC_MID, 16'h0, 5'd0,
                1, sma_pkg::ST_OK, 16'h1234, 5'd1, 6'd2);
        add_row(KIND_SPARE5, MAC_MAX, 16'hFFFF, 5'd31,
                1, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd2);
        add_row(KIND_SPARE6, MAC_MAX, 16'hFFFF, 5'd31,
                1, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd2);
        add_row(KIND_SPARE7, MAC_MAX, 16'hFFFF, 5'd31,
                1, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd2);
        add_row(sma_pkg::KIND_DELETE, 64'h0, 16'h0, 5'd0,
                1, sma_pkg::ST_OK, 16'hFFFF, 5'd0, 6'd1);
        add_row(sma_pkg::KIND_LOOKUP, MAC_MAX, 16'h0, 5'd0,
                1, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd1);
        add_row(sma_pkg::KIND_CLEAR, MAC_MAX, 16'hFFFF, 5'd31,
                1, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_LOOKUP, MAC_MAX, 16'h0, 5'd0,
                1, sma_pkg::ST_NOT_FOUND, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_INSERT, 64'h0123_4567_89AB_CDEF, 16'hBEEF, 5'd0,
                0, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_INSERT, 64'hFEDC_BA98_7654_3210, 16'h0F0F, 5'd0,
                0, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd0);
        add_row(sma_pkg::KIND_READ, 64'h0, 16'h0, 5'd1,
                0, sma_pkg::ST_OK, 16'h0, 5'd0, 6'd0);

        // Hold reset, then release
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].res);

        // Random episodes, rotating through the idling phases
        items_sent = 0;
        ep = 0;
        while (items_sent < RAND_ITEMS)
        begin
            case (ep % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 76;
                end
                default:
                begin
                    sender_idle_pct = 21;
                    stall_pct       = 21;
                end
            endcase
            case (ep % 3)
                0:
                begin
                    // fill from empty to full, then push past the limit
                    send_cmd(sma_pkg::KIND_CLEAR, fresh_mac(), pick_posn());
                    while (entry_cnt < sma_pkg::DEPTH)
                    begin
                        if ($urandom_range(0, 4) != 0)
                            send_cmd(sma_pkg::KIND_INSERT, fresh_mac(), pick_posn());
                        else
                            send_cmd(sma_pkg::KIND_LOOKUP, known_mac(), pick_posn());
                    end
                    send_cmd(sma_pkg::KIND_INSERT, fresh_mac(), pick_posn());
                    send_cmd(sma_pkg::KIND_INSERT, known_mac(), pick_posn());
                    send_cmd(sma_pkg::KIND_LOOKUP, MAC_MAX, pick_posn());
                    send_cmd(sma_pkg::KIND_DELETE, fresh_mac(), pick_posn());
                    send_cmd(sma_pkg::KIND_READ, fresh_mac(), 5'd31);
                end
                1:
                begin
                    // mixed traffic, half the keys taken from the table
                    repeat (40)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 35)
                            k = sma_pkg::KIND_INSERT;
                        else if (roll < 55)
                            k = sma_pkg::KIND_LOOKUP;
                        else if (roll < 75)
                            k = sma_pkg::KIND_DELETE;
                        else if (roll < 90)
                            k = sma_pkg::KIND_READ;
                        else if (roll < 92)
                            k = sma_pkg::KIND_CLEAR;
                        else
                        begin
                            case ($urandom_range(0, 2))
                                0: k = KIND_SPARE5;
                                1: k = KIND_SPARE6;
                                default: k = KIND_SPARE7;
                            endcase
                        end
                        send_cmd(k, $urandom_range(0, 1) ? known_mac() : fresh_mac(),
                                 pick_posn());
                    end
                end
                default:
                begin
                    // drain down to empty
                    while (entry_cnt > 0)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 70)
                            send_cmd(sma_pkg::KIND_DELETE, known_mac(), pick_posn());
                        else if (roll < 85)
                            send_cmd(sma_pkg::KIND_DELETE, fresh_mac(), pick_posn());
                        else
                            send_cmd(sma_pkg::KIND_READ, fresh_mac(), pick_posn());
                    end
                    send_cmd(sma_pkg::KIND_LOOKUP, fresh_mac(), pick_posn());
                end
            endcase
            ep++;
        end
        s_tvalid <= 1'b0;

        // Wait out the outstanding replies, then a short tail
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && table_replies.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
